>>> src/mco2_pkg.sv
// shared types, codes and the crc byte update for the co2 reply checker
package mco2_pkg;

  // reply layout
  localparam logic [7:0]  FUNC_CODE   = 8'h04;
  localparam logic [7:0]  BYTE_COUNT  = 8'h02;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam int unsigned REPLY_LEN   = 7;

  // configuration reset values
  localparam logic [7:0]  ADDR_RESET    = 8'd254;
  localparam logic [15:0] PPM_MIN_RESET = 16'd400;
  localparam logic [15:0] PPM_MAX_RESET = 16'd5000;

  // configuration register byte addresses
  localparam logic [3:0] REG_EXP_ADDR = 4'h0;
  localparam logic [3:0] REG_PPM_MIN  = 4'h4;
  localparam logic [3:0] REG_PPM_MAX  = 4'h8;

  // byte positions inside the reply
  localparam logic [2:0] POS_ADDR   = 3'd0;
  localparam logic [2:0] POS_FUNC   = 3'd1;
  localparam logic [2:0] POS_COUNT  = 3'd2;
  localparam logic [2:0] POS_VAL_HI = 3'd3;
  localparam logic [2:0] POS_VAL_LO = 3'd4;
  localparam logic [2:0] POS_CRC_LO = 3'd5;
  localparam logic [2:0] POS_CRC_HI = 3'd6;
  localparam logic [2:0] POS_DONE   = 3'd7;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_BYTE    = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_BAD_CRC    = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  // one byte of the reflected crc-16, unrolled over eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/modbus_co2_reply_checker.sv
// co2 sensor modbus reply checker: byte-wise header and crc check, at most one word out per reply
// latency: a result word is valid in the cycle after the closing input word is accepted
// throughput: one input word per cycle; the single crc byte update is the longest path
// a new word is taken whenever the result register is empty or being drained
// reset (synchronous, rst_n low): configuration to defaults, reply open and cleared,
// result register empty
module modbus_co2_reply_checker
  import mco2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] co2_ppm
  output logic [2:0]  out_tuser,  // [2:0] status
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [7:0]  exp_addr_r;
  logic [15:0] ppm_min_r, ppm_max_r;

  // reply state
  logic [2:0]  bytes_seen_r, bytes_seen_nxt;
  logic [15:0] crc_acc_r, crc_acc_nxt;
  logic        header_good_r, header_good_nxt;
  logic [7:0]  value_high_r, value_high_nxt;
  logic [7:0]  value_low_r, value_low_nxt;
  logic [7:0]  crc_low_rx_r, crc_low_rx_nxt;
  logic        closed_r, closed_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_ppm_r, out_ppm_nxt;
  status_t     out_status_r, out_status_nxt;

  logic        in_acc;
  logic        emit;
  mode_t       mode;
  logic [7:0]  rx;
  logic [15:0] ppm;
  logic        cfg_wr;

  assign mode      = mode_t'(in_tuser);
  assign rx        = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign ppm       = {value_high_r, value_low_r};

  // configuration access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr)
      REG_EXP_ADDR: cfg_prdata = {24'd0, exp_addr_r};
      REG_PPM_MIN:  cfg_prdata = {16'd0, ppm_min_r};
      REG_PPM_MAX:  cfg_prdata = {16'd0, ppm_max_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r <= ADDR_RESET;
      ppm_min_r  <= PPM_MIN_RESET;
      ppm_max_r  <= PPM_MAX_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        REG_EXP_ADDR: exp_addr_r <= cfg_pwdata[7:0];
        REG_PPM_MIN:  ppm_min_r  <= cfg_pwdata[15:0];
        REG_PPM_MAX:  ppm_max_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // per-word reply update and result decision
  always_comb begin
    bytes_seen_nxt  = bytes_seen_r;
    crc_acc_nxt     = crc_acc_r;
    header_good_nxt = header_good_r;
    value_high_nxt  = value_high_r;
    value_low_nxt   = value_low_r;
    crc_low_rx_nxt  = crc_low_rx_r;
    closed_nxt      = closed_r;
    emit            = 1'b0;
    out_ppm_nxt     = out_ppm_r;
    out_status_nxt  = out_status_r;

    if (in_acc) begin
      if (mode == MODE_START) begin
        bytes_seen_nxt  = 3'd0;
        crc_acc_nxt     = CRC_INIT;
        header_good_nxt = 1'b1;
        value_high_nxt  = 8'd0;
        value_low_nxt   = 8'd0;
        crc_low_rx_nxt  = 8'd0;
        closed_nxt      = 1'b0;
      end else if (!closed_r) begin
        if (mode == MODE_TIMEOUT) begin
          closed_nxt     = 1'b1;
          emit           = 1'b1;
          out_ppm_nxt    = 16'd0;
          out_status_nxt = ST_INCOMPLETE;
        end else if (mode == MODE_BYTE) begin
          case (bytes_seen_r)
            POS_ADDR:   if (rx != exp_addr_r) header_good_nxt = 1'b0;
            POS_FUNC:   if (rx != FUNC_CODE)  header_good_nxt = 1'b0;
            POS_COUNT:  if (rx != BYTE_COUNT) header_good_nxt = 1'b0;
            POS_VAL_HI: value_high_nxt = rx;
            POS_VAL_LO: value_low_nxt  = rx;
            POS_CRC_LO: crc_low_rx_nxt = rx;
            default: ;
          endcase
          if (bytes_seen_r < POS_CRC_LO) begin
            crc_acc_nxt = crc_byte(crc_acc_r, rx);
          end
          if (bytes_seen_r < POS_CRC_HI) begin
            bytes_seen_nxt = bytes_seen_r + 3'd1;
          end else begin
            // closing crc byte: grade the reply
            bytes_seen_nxt = POS_DONE;
            closed_nxt     = 1'b1;
            emit           = 1'b1;
            out_ppm_nxt    = 16'd0;
            if (!header_good_r) begin
              out_status_nxt = ST_BAD_HEADER;
            end else if (crc_acc_r[7:0] != crc_low_rx_r || crc_acc_r[15:8] != rx) begin
              out_status_nxt = ST_BAD_CRC;
            end else if (ppm < ppm_min_r || ppm > ppm_max_r) begin
              out_status_nxt = ST_RANGE;
            end else begin
              out_status_nxt = ST_OK;
              out_ppm_nxt    = ppm;
            end
          end
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // reply state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r  <= 3'd0;
      crc_acc_r     <= CRC_INIT;
      header_good_r <= 1'b1;
      value_high_r  <= 8'd0;
      value_low_r   <= 8'd0;
      crc_low_rx_r  <= 8'd0;
      closed_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      bytes_seen_r  <= bytes_seen_nxt;
      crc_acc_r     <= crc_acc_nxt;
      header_good_r <= header_good_nxt;
      value_high_r  <= value_high_nxt;
      value_low_r   <= value_low_nxt;
      crc_low_rx_r  <= crc_low_rx_nxt;
      closed_r      <= closed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_ppm_r    <= out_ppm_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ppm_r;
  assign out_tuser  = out_status_r;

endmodule
